FILE: rtl/core/mbrx_pkg.sv
`timescale 1ns / 1ps

package mbrx_pkg;

  localparam int MaxFrameDefault = 256;

  localparam logic [7:0]  StationResetVal = 8'd1;
  localparam logic [15:0] SilenceResetVal = 16'd35;
  localparam logic [15:0] CrcInit         = 16'hFFFF;
  localparam logic [15:0] CrcPoly         = 16'hA001;

  localparam logic [7:0] FuncMax      = 8'd127;
  localparam logic [7:0] FuncFixedMin = 8'd1;
  localparam logic [7:0] FuncFixedMax = 8'h04;
  localparam int         FixedLen     = 8;

  localparam int FlagW = 6;
  typedef enum logic [2:0] {
    FlagAddr   = 3'd0,
    FlagLen    = 3'd1,
    FlagFunc   = 3'd2,
    FlagBroken = 3'd3,
    FlagCrc    = 3'd4,
    FlagOk     = 3'd5
  } flag_bit_e;

  localparam int NumCnt = 5;
  typedef enum logic [2:0] {
    CntCrc    = 3'd0,
    CntAddr   = 3'd1,
    CntFunc   = 3'd2,
    CntBroken = 3'd3,
    CntGood   = 3'd4
  } cnt_slot_e;

  typedef enum logic {
    RegStation = 1'b0,
    RegSilence = 1'b1
  } reg_sel_e;

  localparam int PaddrW = 3;

endpackage

FILE: rtl/core/mbrx_in_if.sv
`timescale 1ns / 1ps

interface mbrx_in_if ();
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink (input valid, input op, input rx_byte, output ready);
endinterface

FILE: rtl/core/mbrx_out_if.sv
`timescale 1ns / 1ps

interface mbrx_out_if ();
  logic        valid;
  logic        ready;
  logic [5:0]  status_flags;
  logic [8:0]  frame_length;
  logic [7:0]  function_code;
  logic [15:0] crc_error_count;
  logic [15:0] address_error_count;
  logic [15:0] function_error_count;
  logic [15:0] broken_frame_count;
  logic [15:0] good_frame_count;

  modport source (
    output valid, output status_flags, output frame_length, output function_code,
    output crc_error_count, output address_error_count, output function_error_count,
    output broken_frame_count, output good_frame_count, input ready
  );
  modport sink (
    input valid, input status_flags, input frame_length, input function_code,
    input crc_error_count, input address_error_count, input function_error_count,
    input broken_frame_count, input good_frame_count, output ready
  );
endinterface

FILE: rtl/core/mbrx_crc16.sv
`timescale 1ns / 1ps

module mbrx_crc16 import mbrx_pkg::*; (
  input  logic [15:0] crc_i,
  input  logic [7:0]  data_i,
  output logic [15:0] crc_o
);

  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {8'h00, data_i};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

FILE: rtl/core/modbus_rtu_frame_receiver.sv
`timescale 1ns / 1ps

// Modbus RTU receiver: takes one beat per cycle, either a received byte or a 0.1 ms tick,
// and gives one status beat when the line has been silent for more than silence_ticks
// ticks after the last byte. A beat passes an input register and is processed when the
// result register is free or read; a CRC byte update or a tick compare updates the frame
// state and, at a frame's end, loads the result register. So a new beat is taken every
// cycle unless the sink stalls. The result register holds while the sink stalls, and
// the input side then stalls only once the input register is full too.
// Configuration is by APB at byte address 0 (station address) and 4 (silence ticks).
module modbus_rtu_frame_receiver import mbrx_pkg::*; #(
  parameter int MaxFrame = MaxFrameDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  mbrx_in_if.sink           item_i,
  mbrx_out_if.source        result_o
);

  localparam int CntW = $clog2(MaxFrame + 2);
  localparam logic [CntW-1:0] LenSat = CntW'(MaxFrame + 1);
  localparam logic [CntW-1:0] LenMax = CntW'(MaxFrame);

  // config registers
  logic [7:0]  station_q;
  logic [15:0] silence_ticks_q;
  logic        cfg_wr;
  reg_sel_e    cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = reg_sel_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_q       <= StationResetVal;
      silence_ticks_q <= SilenceResetVal;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        RegStation: station_q       <= pwdata[7:0];
        RegSilence: silence_ticks_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      RegStation: prdata = {24'h0, station_q};
      RegSilence: prdata = {16'h0, silence_ticks_q};
      default:    prdata = '0;
    endcase
  end

  // input register
  logic       s0_valid_q;
  logic       s0_op_q;
  logic [7:0] s0_byte_q;
  logic       s1_go;

  assign s1_go        = s0_valid_q && (!result_o.valid || result_o.ready);
  assign item_i.ready = !s0_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      s0_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      s0_op_q   <= item_i.op;
      s0_byte_q <= item_i.rx_byte;
    end
  end

  // frame state
  logic [15:0]     silence_q, silence_d;
  logic            timer_q, timer_d;
  logic [CntW-1:0] bcnt_q, bcnt_d;
  logic [7:0]      faddr_q, faddr_d;
  logic [7:0]      ffunc_q, ffunc_d;
  logic [15:0]     crc_q, crc_d, crc_next;
  logic [7:0]      held0_q, held0_d, held1_q, held1_d;
  logic [15:0]     evt_q [NumCnt];
  logic [15:0]     evt_d [NumCnt];
  logic [16:0]     silence_inc;
  logic [FlagW-1:0] flags;
  logic            emit;

  mbrx_crc16 u_crc (
    .crc_i  (crc_q),
    .data_i (held0_q),
    .crc_o  (crc_next)
  );

  assign silence_inc = {1'b0, silence_q} + 17'd1;

  always_comb begin
    flags = '0;
    if (faddr_q != station_q) flags[FlagAddr] = 1'b1;
    if (bcnt_q > LenMax) flags[FlagLen] = 1'b1;
    if (ffunc_q > FuncMax) begin
      flags[FlagFunc] = 1'b1;
    end else if (ffunc_q >= FuncFixedMin && ffunc_q <= FuncFixedMax &&
                 bcnt_q != CntW'(FixedLen)) begin
      flags[FlagBroken] = 1'b1;
    end
    if (bcnt_q < CntW'(2)) flags[FlagBroken] = 1'b1;
    if (flags == '0) begin
      if (held0_q == crc_q[7:0] && held1_q == crc_q[15:8]) begin
        flags[FlagOk] = 1'b1;
      end else begin
        flags[FlagCrc] = 1'b1;
      end
    end
  end

  always_comb begin
    silence_d = silence_q;
    timer_d   = timer_q;
    bcnt_d    = bcnt_q;
    faddr_d   = faddr_q;
    ffunc_d   = ffunc_q;
    crc_d     = crc_q;
    held0_d   = held0_q;
    held1_d   = held1_q;
    evt_d     = evt_q;
    emit      = 1'b0;
    if (s1_go) begin
      if (!s0_op_q) begin
        if (bcnt_q == '0) faddr_d = s0_byte_q;
        else if (bcnt_q == CntW'(1)) ffunc_d = s0_byte_q;
        if (bcnt_q >= CntW'(2)) crc_d = crc_next;
        held0_d = held1_q;
        held1_d = s0_byte_q;
        if (bcnt_q < LenSat) bcnt_d = bcnt_q + CntW'(1);
        silence_d = '0;
        timer_d   = 1'b1;
      end else if (timer_q) begin
        if (silence_inc <= {1'b0, silence_ticks_q}) begin
          silence_d = silence_inc[15:0];
        end else begin
          emit = 1'b1;
          if (flags[FlagCrc])    evt_d[CntCrc]    = evt_q[CntCrc] + 16'd1;
          if (flags[FlagAddr])   evt_d[CntAddr]   = evt_q[CntAddr] + 16'd1;
          if (flags[FlagFunc])   evt_d[CntFunc]   = evt_q[CntFunc] + 16'd1;
          if (flags[FlagBroken]) evt_d[CntBroken] = evt_q[CntBroken] + 16'd1;
          if (flags[FlagOk])     evt_d[CntGood]   = evt_q[CntGood] + 16'd1;
          silence_d = '0;
          timer_d   = 1'b0;
          bcnt_d    = '0;
          faddr_d   = '0;
          ffunc_d   = '0;
          crc_d     = CrcInit;
          held0_d   = '0;
          held1_d   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      silence_q <= '0;
      timer_q   <= 1'b0;
      bcnt_q    <= '0;
      faddr_q   <= '0;
      ffunc_q   <= '0;
      crc_q     <= CrcInit;
      held0_q   <= '0;
      held1_q   <= '0;
      for (int i = 0; i < NumCnt; i++) evt_q[i] <= '0;
    end else begin
      silence_q <= silence_d;
      timer_q   <= timer_d;
      bcnt_q    <= bcnt_d;
      faddr_q   <= faddr_d;
      ffunc_q   <= ffunc_d;
      crc_q     <= crc_d;
      held0_q   <= held0_d;
      held1_q   <= held1_d;
      evt_q     <= evt_d;
    end
  end

  // result register
  logic             out_valid_q;
  logic [FlagW-1:0] out_flags_q;
  logic [8:0]       out_len_q;
  logic [7:0]       out_func_q;
  logic [15:0]      out_evt_q [NumCnt];
  logic [31:0]      len_ext;

  assign len_ext = 32'(bcnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_flags_q <= flags;
      out_len_q   <= len_ext[8:0];
      out_func_q  <= ffunc_q;
      out_evt_q   <= evt_d;
    end
  end

  assign result_o.valid                = out_valid_q;
  assign result_o.status_flags         = out_flags_q;
  assign result_o.frame_length         = out_len_q;
  assign result_o.function_code        = out_func_q;
  assign result_o.crc_error_count      = out_evt_q[CntCrc];
  assign result_o.address_error_count  = out_evt_q[CntAddr];
  assign result_o.function_error_count = out_evt_q[CntFunc];
  assign result_o.broken_frame_count   = out_evt_q[CntBroken];
  assign result_o.good_frame_count     = out_evt_q[CntGood];

  // checks
  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !timer_q |-> silence_q == '0)
    else $error("silence count runs while timer stopped");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bcnt_q <= LenSat)
    else $error("byte count past saturation");

  a_crc_verdict_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && (flags[FlagOk] || flags[FlagCrc]) |-> flags[FlagBroken:FlagAddr] == '0)
    else $error("crc verdict mixed with other flags");

  a_good_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && flags[FlagOk] |=> evt_q[CntGood] == $past(evt_q[CntGood]) + 16'd1)
    else $error("good frame counter not advanced");

endmodule

FILE: tb/modbus_rtu_frame_receiver_tb.sv
`timescale 1ns / 1ps

module modbus_rtu_frame_receiver_tb;
  import mbrx_pkg::*;

  localparam int unsigned CycleLimit = 3_000_000;

  typedef logic [7:0] byte_q_t[$];

  typedef enum int {
    FrGoodFixed,
    FrGoodVar,
    FrWrongAddr,
    FrBadCrc,
    FrHighFunc,
    FrFixedBadLen,
    FrShort,
    FrNoise,
    FrLong
  } frame_kind_e;

  typedef struct {
    logic [5:0]  flags;
    logic [8:0]  length;
    logic [7:0]  func;
    logic [15:0] tally [NumCnt];
  } frame_status_t;

  class frame_judge;
    logic [7:0]    station;
    logic [15:0]   silence_limit;
    logic [15:0]   quiet_ticks;
    bit            timer_on;
    int unsigned   nbytes;
    logic [7:0]    addr_byte;
    logic [7:0]    func_byte;
    logic [15:0]   crc;
    logic [7:0]    tail [2];
    logic [15:0]   tally [NumCnt];
    frame_status_t pending[$];
    int unsigned   mismatches;
    int unsigned   checked;

    function new();
      station       = StationResetVal;
      silence_limit = SilenceResetVal;
      mismatches    = 0;
      checked       = 0;
      foreach (tally[i]) tally[i] = '0;
      restart_frame();
    endfunction

    static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int i = 0; i < 8; i++) r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
      return r;
    endfunction

    function void restart_frame();
      quiet_ticks = '0;
      timer_on    = 1'b0;
      nbytes      = 0;
      addr_byte   = '0;
      func_byte   = '0;
      crc         = CrcInit;
      tail[0]     = '0;
      tail[1]     = '0;
    endfunction

    function void set_reg(reg_sel_e r, logic [31:0] v);
      if (r == RegStation) station = v[7:0];
      else silence_limit = v[15:0];
    endfunction

    function void note_beat(logic op, logic [7:0] b);
      logic [5:0]    fl;
      frame_status_t s;
      if (op == 1'b0) begin
        if (nbytes == 0) addr_byte = b;
        else if (nbytes == 1) func_byte = b;
        if (nbytes >= 2) crc = crc_step(crc, tail[0]);
        tail[0] = tail[1];
        tail[1] = b;
        if (nbytes < MaxFrameDefault + 1) nbytes++;
        quiet_ticks = '0;
        timer_on    = 1'b1;
        return;
      end
      if (!timer_on) return;
      // compare one bit wider than the counter
      if ({1'b0, quiet_ticks} + 17'd1 <= {1'b0, silence_limit}) begin
        quiet_ticks = quiet_ticks + 16'd1;
        return;
      end
      fl = '0;
      if (addr_byte != station) fl[FlagAddr] = 1'b1;
      if (nbytes > MaxFrameDefault) fl[FlagLen] = 1'b1;
      if (func_byte > FuncMax) fl[FlagFunc] = 1'b1;
      else if (func_byte >= FuncFixedMin && func_byte <= FuncFixedMax && nbytes != FixedLen)
        fl[FlagBroken] = 1'b1;
      if (nbytes < 2) fl[FlagBroken] = 1'b1;
      if (fl == '0) begin
        if (tail[0] == crc[7:0] && tail[1] == crc[15:8]) fl[FlagOk] = 1'b1;
        else fl[FlagCrc] = 1'b1;
      end
      if (fl[FlagCrc]) tally[CntCrc] = tally[CntCrc] + 16'd1;
      if (fl[FlagAddr]) tally[CntAddr] = tally[CntAddr] + 16'd1;
      if (fl[FlagFunc]) tally[CntFunc] = tally[CntFunc] + 16'd1;
      if (fl[FlagBroken]) tally[CntBroken] = tally[CntBroken] + 16'd1;
      if (fl[FlagOk]) tally[CntGood] = tally[CntGood] + 16'd1;
      s.flags  = fl;
      s.length = 9'(nbytes);
      s.func   = func_byte;
      s.tally  = tally;
      pending.push_back(s);
      restart_frame();
    endfunction

    function void compare(string what, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", what, want, got);
        mismatches++;
      end
    endfunction

    function void check_status(frame_status_t got);
      frame_status_t want;
      checked++;
      if (pending.size() == 0) begin
        $error("status beat with no frame waiting");
        mismatches++;
        return;
      end
      want = pending.pop_front();
      compare("status_flags", want.flags, got.flags);
      compare("frame_length", want.length, got.length);
      compare("function_code", want.func, got.func);
      compare("crc_error_count", want.tally[CntCrc], got.tally[CntCrc]);
      compare("address_error_count", want.tally[CntAddr], got.tally[CntAddr]);
      compare("function_error_count", want.tally[CntFunc], got.tally[CntFunc]);
      compare("broken_frame_count", want.tally[CntBroken], got.tally[CntBroken]);
      compare("good_frame_count", want.tally[CntGood], got.tally[CntGood]);
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  mbrx_in_if  beat_if ();
  mbrx_out_if status_if ();

  frame_judge  model = new();
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned cycles = 0;

  modbus_rtu_frame_receiver u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .item_i   (beat_if),
    .result_o (status_if)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    frame_status_t got;
    if (rst_ni && status_if.valid && status_if.ready) begin
      got.flags            = status_if.status_flags;
      got.length           = status_if.frame_length;
      got.func             = status_if.function_code;
      got.tally[CntCrc]    = status_if.crc_error_count;
      got.tally[CntAddr]   = status_if.address_error_count;
      got.tally[CntFunc]   = status_if.function_error_count;
      got.tally[CntBroken] = status_if.broken_frame_count;
      got.tally[CntGood]   = status_if.good_frame_count;
      model.check_status(got);
    end
  end

  // result side stalls, with one long hold once results are flowing
  initial begin
    int       mode;
    int       span;
    logic [7:0] pat;
    bit       held;
    held = 1'b0;
    status_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      pat  = 8'($urandom);
      for (int i = 0; i < span; i++) begin
        @(posedge clk_i);
        if (!held && model.checked >= 8) begin
          status_if.ready <= 1'b0;
          held = 1'b1;
          repeat (400) @(posedge clk_i);
        end else begin
          case (mode)
            0: status_if.ready <= 1'b1;
            1: status_if.ready <= 1'($urandom_range(0, 1));
            2: status_if.ready <= pat[i % 8];
            default: status_if.ready <= ($urandom_range(0, 7) != 0);
          endcase
        end
      end
    end
  end

  task automatic send_item(input logic op, input logic [7:0] b);
    int gap;
    beat_if.valid   <= 1'b1;
    beat_if.op      <= op;
    beat_if.rx_byte <= b;
    do @(posedge clk_i); while (!beat_if.ready);
    model.note_beat(op, b);
    items_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        beat_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_frame(input byte_q_t f);
    int pause;
    foreach (f[i]) begin
      // ticks inside the frame that do not exceed the silence limit
      if (i > 0 && $urandom_range(0, 7) == 0) begin
        pause = $urandom_range(0, model.silence_limit);
        repeat (pause) send_item(1'b1, 8'($urandom));
      end
      send_item(1'b0, f[i]);
    end
    pause = model.silence_limit + 1 + $urandom_range(0, 2);
    repeat (pause) send_item(1'b1, 8'($urandom));
  endtask

  task automatic drain();
    beat_if.valid <= 1'b0;
    while (model.pending.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic apb_write(input reg_sel_e r, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    model.set_reg(r, v);
    @(posedge clk_i);
  endtask

  function automatic byte_q_t make_frame(frame_kind_e kind, int size);
    byte_q_t     f;
    logic [15:0] c;
    logic [7:0]  fn;
    int          body;
    int          idx;
    f = {};
    case (kind)
      FrGoodFixed, FrWrongAddr: begin
        f.push_back(model.station);
        f.push_back(8'($urandom_range(1, 4)));
        repeat (4) f.push_back(8'($urandom));
      end
      FrGoodVar, FrBadCrc: begin
        fn = 8'($urandom_range(0, 123));
        if (fn != 0) fn = fn + 8'd4;
        f.push_back(model.station);
        f.push_back(fn);
        body = $urandom_range(0, 18);
        repeat (body) f.push_back(8'($urandom));
      end
      FrHighFunc: begin
        f.push_back(model.station);
        f.push_back(8'($urandom_range(128, 255)));
        body = $urandom_range(0, 10);
        repeat (body) f.push_back(8'($urandom));
      end
      FrFixedBadLen: begin
        f.push_back(model.station);
        f.push_back(8'($urandom_range(1, 4)));
        body = $urandom_range(0, 12);
        if (body == 4) body = 13;
        repeat (body) f.push_back(8'($urandom));
      end
      FrLong: begin
        f.push_back(model.station);
        f.push_back(8'($urandom_range(5, 127)));
        repeat (size - 4) f.push_back(8'($urandom));
      end
      FrShort: begin
        f.push_back(($urandom_range(0, 1) == 0) ? model.station : 8'($urandom));
        return f;
      end
      default: begin
        body = $urandom_range(1, 16);
        repeat (body) f.push_back(8'($urandom));
        return f;
      end
    endcase
    c = CrcInit;
    foreach (f[i]) c = frame_judge::crc_step(c, f[i]);
    f.push_back(c[7:0]);
    f.push_back(c[15:8]);
    if (kind == FrWrongAddr) f[0] = f[0] ^ 8'($urandom_range(1, 255));
    if (kind == FrBadCrc) begin
      idx = $urandom_range(2, f.size() - 1);
      f[idx] = f[idx] ^ 8'(1 << $urandom_range(0, 7));
    end
    return f;
  endfunction

  task automatic run_traffic(input int n);
    int          stop;
    int          r;
    frame_kind_e k;
    stop = items_sent + n;
    while (items_sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 35) k = FrGoodFixed;
      else if (r < 60) k = FrGoodVar;
      else if (r < 67) k = FrWrongAddr;
      else if (r < 74) k = FrBadCrc;
      else if (r < 80) k = FrHighFunc;
      else if (r < 86) k = FrFixedBadLen;
      else if (r < 91) k = FrShort;
      else if (r < 99) k = FrNoise;
      else k = FrLong;
      send_frame(make_frame(k, $urandom_range(256, 262)));
      if ($urandom_range(0, 9) == 0) send_item(1'b1, 8'($urandom));
    end
  endtask

  initial begin
    byte_q_t f;
    rst_ni          <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    beat_if.valid   <= 1'b0;
    beat_if.op      <= 1'b0;
    beat_if.rx_byte <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings
    send_frame(make_frame(FrGoodFixed, 0));
    send_frame(make_frame(FrWrongAddr, 0));
    drain();

    apb_write(RegStation, 32'h0000_0000);
    apb_write(RegSilence, 32'd1);
    send_item(1'b1, 8'hFF);
    send_frame(make_frame(FrShort, 0));
    f = {8'h00, 8'h00};
    send_frame(f);
    f = {8'hFF, 8'hFF};
    send_frame(f);
    for (int k = FrGoodFixed; k <= FrNoise; k++) send_frame(make_frame(frame_kind_e'(k), 0));
    run_traffic(150);
    drain();

    apb_write(RegStation, 32'h0000_00FF);
    apb_write(RegSilence, 32'd4);
    send_frame(make_frame(FrLong, 256));
    send_frame(make_frame(FrLong, 260));
    run_traffic(100);
    drain();

    apb_write(RegStation, 32'($urandom_range(0, 255)));
    apb_write(RegSilence, 32'($urandom_range(2, 8)));
    run_traffic(100);
    drain();

    $display("%0d beats sent, %0d frames judged with %0d good", items_sent, model.checked,
             model.tally[CntGood]);
    $display("settings swept: several stations and silence limits, short and long frames");
    if (model.mismatches == 0 && model.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
